// ===== src/sc1dec_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sc1dec_pkg
// Scan code set 1 constants, modifier mask update and US layout lookup
// ----------------------------------------------------------------------------
package sc1dec_pkg;

  typedef logic [7:0] scan_code_t;
  typedef logic [7:0] mod_mask_t;
  typedef logic [6:0] ascii_t;

  // scan codes with special meaning
  localparam scan_code_t SC_PREFIX_E0  = 8'hE0;
  localparam scan_code_t SC_LSHIFT_MK  = 8'h2A;
  localparam scan_code_t SC_LSHIFT_BRK = 8'hAA;
  localparam scan_code_t SC_RSHIFT_MK  = 8'h36;
  localparam scan_code_t SC_RSHIFT_BRK = 8'hB6;
  localparam scan_code_t SC_CTRL_MK    = 8'h1D;
  localparam scan_code_t SC_CTRL_BRK   = 8'h9D;
  localparam scan_code_t SC_ALT_MK     = 8'h38;
  localparam scan_code_t SC_ALT_BRK    = 8'hB8;

  // bit positions in the modifier mask
  localparam int unsigned MB_LSHIFT = 7;
  localparam int unsigned MB_RSHIFT = 6;
  localparam int unsigned MB_LCTRL  = 5;
  localparam int unsigned MB_RCTRL  = 4;
  localparam int unsigned MB_LALT   = 3;
  localparam int unsigned MB_RALT   = 2;
  localparam int unsigned MB_E0     = 1;

  // modifier mask after one scan code byte
  function automatic mod_mask_t next_mask(mod_mask_t m, scan_code_t code);
    mod_mask_t r;
    r = m;
    if (!m[MB_E0]) begin
      unique case (code)
        SC_LSHIFT_MK:  r[MB_LSHIFT] = 1'b1;
        SC_LSHIFT_BRK: r[MB_LSHIFT] = 1'b0;
        SC_RSHIFT_MK:  r[MB_RSHIFT] = 1'b1;
        SC_RSHIFT_BRK: r[MB_RSHIFT] = 1'b0;
        SC_CTRL_MK:    r[MB_LCTRL]  = 1'b1;
        SC_CTRL_BRK:   r[MB_LCTRL]  = 1'b0;
        SC_ALT_MK:     r[MB_LALT]   = 1'b1;
        SC_ALT_BRK:    r[MB_LALT]   = 1'b0;
        SC_PREFIX_E0:  r[MB_E0]     = 1'b1;
        default:       r = m;
      endcase
    end else begin
      // extended key: only right ctrl / right alt move, prefix always drops
      unique case (code)
        SC_CTRL_MK:  r[MB_RCTRL] = 1'b1;
        SC_CTRL_BRK: r[MB_RCTRL] = 1'b0;
        SC_ALT_MK:   r[MB_RALT]  = 1'b1;
        SC_ALT_BRK:  r[MB_RALT]  = 1'b0;
        default:     r = m;
      endcase
      r[MB_E0] = 1'b0;
    end
    r[0] = 1'b0;
    return r;
  endfunction

  // unshifted US layout, 0 where there is no printable mapping
  function automatic ascii_t plain_char(scan_code_t code);
    ascii_t c;
    unique case (code)
      8'h02: c = 7'h31;  8'h03: c = 7'h32;  8'h04: c = 7'h33;  8'h05: c = 7'h34;
      8'h06: c = 7'h35;  8'h07: c = 7'h36;  8'h08: c = 7'h37;  8'h09: c = 7'h38;
      8'h0A: c = 7'h39;  8'h0B: c = 7'h30;  8'h0C: c = 7'h2D;  8'h0D: c = 7'h3D;
      8'h10: c = 7'h71;  8'h11: c = 7'h77;  8'h12: c = 7'h65;  8'h13: c = 7'h72;
      8'h14: c = 7'h74;  8'h15: c = 7'h79;  8'h16: c = 7'h75;  8'h17: c = 7'h69;
      8'h18: c = 7'h6F;  8'h19: c = 7'h70;  8'h1A: c = 7'h5B;  8'h1B: c = 7'h5D;
      8'h1C: c = 7'h0A;
      8'h1E: c = 7'h61;  8'h1F: c = 7'h73;  8'h20: c = 7'h64;  8'h21: c = 7'h66;
      8'h22: c = 7'h67;  8'h23: c = 7'h68;  8'h24: c = 7'h6A;  8'h25: c = 7'h6B;
      8'h26: c = 7'h6C;  8'h27: c = 7'h3B;  8'h28: c = 7'h27;  8'h29: c = 7'h60;
      8'h2B: c = 7'h5C;
      8'h2C: c = 7'h7A;  8'h2D: c = 7'h78;  8'h2E: c = 7'h63;  8'h2F: c = 7'h76;
      8'h30: c = 7'h62;  8'h31: c = 7'h6E;  8'h32: c = 7'h6D;  8'h33: c = 7'h2C;
      8'h34: c = 7'h2E;  8'h35: c = 7'h2F;  8'h39: c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  // shifted US layout
  function automatic ascii_t shift_char(scan_code_t code);
    ascii_t c;
    unique case (code)
      8'h02: c = 7'h21;  8'h03: c = 7'h40;  8'h04: c = 7'h23;  8'h05: c = 7'h24;
      8'h06: c = 7'h25;  8'h07: c = 7'h5E;  8'h08: c = 7'h26;  8'h09: c = 7'h2A;
      8'h0A: c = 7'h28;  8'h0B: c = 7'h29;  8'h0C: c = 7'h5F;  8'h0D: c = 7'h2B;
      8'h10: c = 7'h51;  8'h11: c = 7'h57;  8'h12: c = 7'h45;  8'h13: c = 7'h52;
      8'h14: c = 7'h54;  8'h15: c = 7'h59;  8'h16: c = 7'h55;  8'h17: c = 7'h49;
      8'h18: c = 7'h4F;  8'h19: c = 7'h50;  8'h1A: c = 7'h7B;  8'h1B: c = 7'h7D;
      8'h1C: c = 7'h0A;
      8'h1E: c = 7'h41;  8'h1F: c = 7'h53;  8'h20: c = 7'h44;  8'h21: c = 7'h46;
      8'h22: c = 7'h47;  8'h23: c = 7'h48;  8'h24: c = 7'h4A;  8'h25: c = 7'h4B;
      8'h26: c = 7'h4C;  8'h27: c = 7'h3A;  8'h28: c = 7'h22;  8'h29: c = 7'h7E;
      8'h2B: c = 7'h7C;
      8'h2C: c = 7'h5A;  8'h2D: c = 7'h58;  8'h2E: c = 7'h43;  8'h2F: c = 7'h56;
      8'h30: c = 7'h42;  8'h31: c = 7'h4E;  8'h32: c = 7'h4D;  8'h33: c = 7'h3C;
      8'h34: c = 7'h3E;  8'h35: c = 7'h3F;  8'h39: c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== src/scancode_set1_ascii_decoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scancode_set1_ascii_decoder_core
// Set-1 scan code to ASCII decoder with shift/ctrl/alt and E0 prefix tracking
// ----------------------------------------------------------------------------
// Takes one scan code byte per item and returns one result per item: the
// ASCII character from a US layout (0 for break codes, modifiers and keys
// without a printable mapping) and the modifier mask after that byte. The
// block sustains one item per clock when the output side is not stalled. An
// accepted byte is held in the input register; the modifier register and
// the result register then load together once the result register is free
// or drains, and the result is presented from the result register. The
// rate is set by the modifier register, which closes its update loop through
// the mask update logic once per cycle.
// ----------------------------------------------------------------------------
module scancode_set1_ascii_decoder_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  sc1dec_pkg::scan_code_t   in_scan_code,
  output logic                     out_valid,
  input  logic                     out_ready,
  output sc1dec_pkg::ascii_t       out_ascii_char,
  output sc1dec_pkg::mod_mask_t    out_modifier_mask
);
  import sc1dec_pkg::*;

  logic        a_valid_r, a_valid_nxt;
  scan_code_t  a_code_r;
  mod_mask_t   mask_r, mask_nxt;
  logic        o_valid_r, o_valid_nxt;
  ascii_t      o_char_r, o_char_nxt;
  mod_mask_t   o_mask_r;
  logic        adv;
  logic        in_acc;

  // handshake: the input stage advances when the result register is free or drains
  assign adv      = a_valid_r && (!o_valid_r || out_ready);
  assign in_ready = !a_valid_r || adv;
  assign in_acc   = in_valid && in_ready;

  // mask update and character lookup for the item in the input register
  always_comb begin
    mask_nxt    = next_mask(mask_r, a_code_r);
    o_char_nxt  = (mask_nxt[MB_LSHIFT] || mask_nxt[MB_RSHIFT]) ?
                  shift_char(a_code_r) : plain_char(a_code_r);
    a_valid_nxt = in_acc || (a_valid_r && !adv);
    o_valid_nxt = adv || (o_valid_r && !out_ready);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
      mask_r    <= '0;
    end else begin
      a_valid_r <= a_valid_nxt;
      o_valid_r <= o_valid_nxt;
      if (adv) begin
        mask_r <= mask_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_code_r <= in_scan_code;
    end
    if (adv) begin
      o_char_r <= o_char_nxt;
      o_mask_r <= mask_nxt;
    end
  end

  assign out_valid         = o_valid_r;
  assign out_ascii_char    = o_char_r;
  assign out_modifier_mask = o_mask_r;

`ifndef SYNTH
  // the low mask bit never carries anything
  a_mask_bit0 : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_modifier_mask[0])
    else $error("modifier mask bit 0 set");

  // an unprefixed E0 byte leaves the prefix pending
  a_prefix_set : assert property (@(posedge clk) disable iff (!rst_n)
    (adv && a_code_r == SC_PREFIX_E0 && !mask_r[MB_E0]) |=> mask_r[MB_E0])
    else $error("E0 prefix not recorded");

  // any byte after a pending prefix clears it
  a_prefix_clr : assert property (@(posedge clk) disable iff (!rst_n)
    (adv && mask_r[MB_E0]) |=> !mask_r[MB_E0])
    else $error("E0 prefix not cleared");

  // break codes never produce a character
  a_break_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (adv && a_code_r[7]) |=> (out_ascii_char == '0))
    else $error("break code produced a character");

  // input stalls only when both stages are full and the output is held
  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (a_valid_r && o_valid_r && !out_ready))
    else $error("input stalled without cause");
`endif

endmodule
